[rtl/omq_pkg.sv]
// Shared constants, codes and types of the ordered match queue.
package omq_pkg;

    localparam int DEPTH     = 64;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam int KEY_LO_W  = 64;
    localparam int KEY_HI_W  = 16;
    localparam int VAL_W     = 16;
    localparam int STAT_W    = 3;
    localparam int OCC_W     = 7;

    localparam int S_DATA_W  = 96;
    localparam int S_USER_W  = 1;
    localparam int M_DATA_W  = 104;
    localparam int M_USER_W  = 3;

    localparam int FQ_DEPTH  = 2;
    localparam int FQ_PTR_W  = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int FQ_CNT_W  = $clog2(FQ_DEPTH + 1);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_ZERO   = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_ADDED   = 3'd0,
        STAT_REMOVED = 3'd1,
        STAT_ZERO    = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_DUP     = 3'd4,
        STAT_EMPTY   = 3'd5,
        STAT_NOMATCH = 3'd6
    } status_t;

    typedef struct packed {
        logic [VAL_W-1:0]    value;
        logic [KEY_HI_W-1:0] key_high;
        logic [KEY_LO_W-1:0] key_low;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int M_PAD_W = M_DATA_W - ENTRY_W - OCC_W;

    typedef struct packed {
        op_t    op;
        entry_t entry;
    } cmd_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             shift_en;
        logic [DEPTH-1:0] shift_mask;
    } cell_ctrl_t;

endpackage

[rtl/omq_front.sv]
// Request decoder: unpacks an input item and classifies it into a command.
module omq_front
(
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [omq_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [omq_pkg::S_USER_W-1:0] s_tuser,
    input  logic                         can_push,
    output logic                         push,
    output omq_pkg::cmd_t                push_cmd
);
    import omq_pkg::*;

    entry_t req_entry;

    assign req_entry = entry_t'(s_tdata[ENTRY_W-1:0]);
    assign s_tready  = can_push;
    assign push      = s_tvalid && can_push;

    always_comb
    begin
        push_cmd.entry = req_entry;
        unique case (s_tuser[0])
            REQ_INSERT:
            begin
                push_cmd.op = (req_entry.value == '0) ? OP_ZERO : OP_INSERT;
            end
            REQ_REMOVE:
            begin
                push_cmd.op = OP_REMOVE;
            end
            default:
            begin
                push_cmd.op = OP_INSERT;
            end
        endcase
    end

endmodule

[rtl/omq_cmd_fifo.sv]
// Short command queue between the request decoder and the queue engine.
module omq_cmd_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  omq_pkg::cmd_t push_cmd,
    output logic          can_push,
    input  logic          pop,
    output omq_pkg::cmd_t pop_cmd,
    output logic          not_empty
);
    import omq_pkg::*;

    cmd_t                mem_reg [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] wr_ptr_reg;
    logic [FQ_PTR_W-1:0] wr_ptr_next;
    logic [FQ_PTR_W-1:0] rd_ptr_reg;
    logic [FQ_PTR_W-1:0] rd_ptr_next;
    logic [FQ_CNT_W-1:0] fill_reg;
    logic [FQ_CNT_W-1:0] fill_next;

    assign can_push  = (fill_reg != FQ_CNT_W'(FQ_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + FQ_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + FQ_PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FQ_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[rtl/omq_cells.sv]
// Entry cells: storage, per-entry compare, append and compaction shift.
module omq_cells
(
    input  logic                       clk,
    input  omq_pkg::cell_ctrl_t        ctrl,
    input  omq_pkg::entry_t            wr_entry,
    input  omq_pkg::entry_t            cmp_entry,
    input  logic [omq_pkg::CNT_W-1:0]  count,
    input  logic [omq_pkg::DEPTH-1:0]  sel,
    output logic [omq_pkg::DEPTH-1:0]  key_hit,
    output logic [omq_pkg::DEPTH-1:0]  val_hit,
    output omq_pkg::entry_t            rd_entry
);
    import omq_pkg::*;

    entry_t cell_reg [DEPTH];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g < DEPTH - 1)
        begin : g_shift
            always_ff @(posedge clk)
            begin
                if (ctrl.shift_en && ctrl.shift_mask[g])
                begin
                    cell_reg[g] <= cell_reg[g + 1];
                end
                else if (ctrl.wr_en && (ctrl.wr_idx == IDX_W'(g)))
                begin
                    cell_reg[g] <= wr_entry;
                end
            end
        end
        else
        begin : g_top
            always_ff @(posedge clk)
            begin
                if (ctrl.wr_en && (ctrl.wr_idx == IDX_W'(g)))
                begin
                    cell_reg[g] <= wr_entry;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            key_hit[i] = (CNT_W'(i) < count)
                      && (cell_reg[i].key_low  == cmp_entry.key_low)
                      && (cell_reg[i].key_high == cmp_entry.key_high);
            val_hit[i] = (CNT_W'(i) < count)
                      && (cell_reg[i].value == cmp_entry.value);
        end
    end

    logic [ENTRY_W-1:0] rd_acc;

    always_comb
    begin
        rd_acc = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (sel[i])
            begin
                rd_acc = rd_acc | cell_reg[i];
            end
        end
    end

    assign rd_entry = entry_t'(rd_acc);

endmodule

[rtl/omq_back.sv]
// Queue engine: compare, resolve, update the cells and hold the result item.
module omq_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fifo_not_empty,
    input  omq_pkg::cmd_t              fifo_cmd,
    output logic                       fifo_pop,
    output omq_pkg::cell_ctrl_t        ctrl,
    output omq_pkg::entry_t            wr_entry,
    output omq_pkg::entry_t            cmp_entry,
    output logic [omq_pkg::CNT_W-1:0]  count,
    output logic [omq_pkg::DEPTH-1:0]  sel,
    input  logic [omq_pkg::DEPTH-1:0]  key_hit,
    input  logic [omq_pkg::DEPTH-1:0]  val_hit,
    input  omq_pkg::entry_t            rd_entry,
    output logic                       res_valid,
    input  logic                       res_ready,
    output omq_pkg::status_t           res_status,
    output omq_pkg::entry_t            res_entry,
    output logic [omq_pkg::OCC_W-1:0]  res_occ
);
    import omq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_RES  = 3'b100
    } state_t;

    localparam logic [DEPTH-1:0] LSB_ONE = {{(DEPTH - 1){1'b0}}, 1'b1};

    state_t           state_reg;
    state_t           state_next;
    cmd_t             cmd_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [DEPTH-1:0] key_hit_reg;
    logic [DEPTH-1:0] val_hit_reg;
    logic             res_valid_reg;
    status_t          status_reg;
    status_t          status_next;
    entry_t           out_entry_reg;
    entry_t           out_entry_next;
    logic [OCC_W-1:0] occ_reg;

    logic             out_free;
    logic             done;
    logic             do_write;
    logic             do_shift;
    logic [DEPTH-1:0] first_hit;

    assign out_free  = !res_valid_reg || res_ready;
    assign done      = (state_reg == S_RES) && out_free;
    assign fifo_pop  = fifo_not_empty && ((state_reg == S_IDLE) || done);

    assign first_hit = val_hit_reg & (~val_hit_reg + LSB_ONE);
    assign sel       = first_hit;
    assign cmp_entry = cmd_reg.entry;
    assign wr_entry  = cmd_reg.entry;
    assign count     = count_reg;

    assign ctrl.wr_en      = done && do_write;
    assign ctrl.wr_idx     = count_reg[IDX_W-1:0];
    assign ctrl.shift_en   = done && do_shift;
    assign ctrl.shift_mask = ~(first_hit - LSB_ONE);

    always_comb
    begin
        status_next    = STAT_ZERO;
        out_entry_next = '0;
        count_next     = count_reg;
        do_write       = 1'b0;
        do_shift       = 1'b0;
        unique case (cmd_reg.op)
            OP_ZERO:
            begin
                status_next = STAT_ZERO;
            end
            OP_INSERT:
            begin
                if (count_reg >= CNT_W'(DEPTH))
                begin
                    status_next = STAT_FULL;
                end
                else if (key_hit_reg != '0)
                begin
                    status_next = STAT_DUP;
                end
                else
                begin
                    status_next = STAT_ADDED;
                    do_write    = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else if (val_hit_reg == '0)
                begin
                    status_next = STAT_NOMATCH;
                end
                else
                begin
                    status_next    = STAT_REMOVED;
                    do_shift       = 1'b1;
                    out_entry_next = rd_entry;
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = STAT_ZERO;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fifo_pop)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_RES;
            end
            S_RES:
            begin
                if (done)
                begin
                    state_next = fifo_pop ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fifo_pop)
        begin
            cmd_reg <= fifo_cmd;
        end
        if (state_reg == S_CMP)
        begin
            key_hit_reg <= key_hit;
            val_hit_reg <= val_hit;
        end
        if (done)
        begin
            status_reg    <= status_next;
            out_entry_reg <= out_entry_next;
            occ_reg       <= OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                count_reg <= count_next;
            end
            if (done)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_status = status_reg;
    assign res_entry  = out_entry_reg;
    assign res_occ    = occ_reg;

endmodule

[rtl/ordered_match_queue.sv]
// Top level of the ordered match queue: decoder, command queue, engine and cells.
//
// Input channel (s_*): one item per request. s_tuser carries the request
// kind (insert or remove); s_tdata carries key_low, key_high and value.
// Output channel (m_*): exactly one item per request, in request order.
// m_tuser carries the status; m_tdata carries the removed key and value
// (zero unless removed) and the occupancy after the request.
// With the command queue empty and the output free, an accepted request passes
// through the command queue, the engine's compare state and its resolve state
// before its result item shows on m_tvalid. The engine works on one request at
// a time, through its compare state (all held entries compared at once into
// registered hit vectors) and its resolve state (first hit picked, cells
// appended or shifted down by one); the next starts once the last is resolved.
// A two-entry command queue lets requests be accepted while the engine works.
// Reset empties the queue and the command queue at once; no clearing pass.
// When the receiver stalls, the result item holds, the engine waits in its
// resolve state and further requests fill the command queue before
// s_tready drops.
module ordered_match_queue
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // key_low[63:0], key_high[79:64], value[95:80]
    input  logic [omq_pkg::S_DATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic [omq_pkg::S_USER_W-1:0] s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_key_low[63:0], out_key_high[79:64], out_value[95:80],
    // occupancy[102:96], zero[103]
    output logic [omq_pkg::M_DATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [omq_pkg::M_USER_W-1:0] m_tuser
);
    import omq_pkg::*;

    logic             can_push;
    logic             push;
    cmd_t             push_cmd;
    logic             fifo_pop;
    cmd_t             fifo_cmd;
    logic             fifo_not_empty;
    cell_ctrl_t       ctrl;
    entry_t           wr_entry;
    entry_t           cmp_entry;
    logic [CNT_W-1:0] count;
    logic [DEPTH-1:0] sel;
    logic [DEPTH-1:0] key_hit;
    logic [DEPTH-1:0] val_hit;
    entry_t           rd_entry;
    status_t          res_status;
    entry_t           res_entry;
    logic [OCC_W-1:0] res_occ;

    omq_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .can_push (can_push),
        .push     (push),
        .push_cmd (push_cmd)
    );

    omq_cmd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .can_push  (can_push),
        .pop       (fifo_pop),
        .pop_cmd   (fifo_cmd),
        .not_empty (fifo_not_empty)
    );

    omq_cells u_cells
    (
        .clk       (clk),
        .ctrl      (ctrl),
        .wr_entry  (wr_entry),
        .cmp_entry (cmp_entry),
        .count     (count),
        .sel       (sel),
        .key_hit   (key_hit),
        .val_hit   (val_hit),
        .rd_entry  (rd_entry)
    );

    omq_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .fifo_not_empty (fifo_not_empty),
        .fifo_cmd       (fifo_cmd),
        .fifo_pop       (fifo_pop),
        .ctrl           (ctrl),
        .wr_entry       (wr_entry),
        .cmp_entry      (cmp_entry),
        .count          (count),
        .sel            (sel),
        .key_hit        (key_hit),
        .val_hit        (val_hit),
        .rd_entry       (rd_entry),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .res_status     (res_status),
        .res_entry      (res_entry),
        .res_occ        (res_occ)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, res_occ, res_entry};
    assign m_tuser = res_status;

endmodule
